// ===== src/dwt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dwt_pkg;

    localparam int DEF_MAX_WORD_LEN = 255;

    // result queue: must hold the two results one item can make
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0a;
    localparam logic [6:0] CH_CR    = 7'h0d;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SKIP    = 2'd1,
        PH_COLLECT = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [6:0] ch;
        logic [7:0] pos;
        logic [7:0] len;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t r0;
        result_t r1;
    } push_t;

endpackage

`default_nettype wire

// ===== src/delimited_word_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Word tokenizer for a delimited character stream.
// Input stream (s_axis_*): tuser carries the opcode (begin word, character,
// end of input), tdata carries the delimiter byte and the character byte.
// A begin transfer sets the delimiter and starts a word; character transfers
// follow; the word ends on the delimiter, on end of input or at the length
// limit. A space delimiter also skips leading blanks and ends on tab/LF/CR.
// Output stream (m_axis_*): one transfer per stored character (tuser 0,
// char and position) and one completion transfer (tuser 1, length) that
// carries tlast.
// Throughput: one input transfer per cycle, sustained, as long as the
// receiver takes one result per cycle. An item that produces two results
// (the character hitting the length limit) is absorbed by the 4-entry
// result queue. Each input transfer passes the input register, then is
// decoded into the result queue, whose occupancy drives m_axis_tvalid.
// Reset clears the word state to idle and empties the queue.
// When the receiver stalls, the queue fills and s_axis_tready drops once it
// can no longer take the two results one item may produce.

module delimited_word_tokenizer
    import dwt_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [7:0] delimiter, [15:8] char_in
    input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] out_char, [14:7] out_position,
                                        // [22:15] word_length, [23] zero
    output logic        m_axis_tuser,   // [0] out_kind
    output logic        m_axis_tlast    // last
);

    // input register stage
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] delim_reg;
    logic [7:0] char_reg;

    logic    room;
    logic    go;
    push_t   push;
    result_t out_res;

    assign go            = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg    <= s_axis_tuser;
            delim_reg <= s_axis_tdata[7:0];
            char_reg  <= s_axis_tdata[15:8];
        end
    end

    // word state and result decode
    dwt_core #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .op      (op_reg),
        .delim   (delim_reg),
        .char_in (char_reg),
        .push    (push)
    );

    // result queue, also the output register
    dwt_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res.len, out_res.pos, out_res.ch};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== src/dwt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwt_core
    import dwt_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        go,
    input  wire  [1:0] op,
    input  wire  [7:0] delim,
    input  wire  [7:0] char_in,
    output push_t      push
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_WORD_LEN);

    phase_t     phase_reg, phase_next;
    logic [6:0] delim_reg, delim_next;
    logic [7:0] count_reg, count_next;

    logic [6:0] c;
    logic [6:0] d;
    logic       ctl;
    logic       active;
    logic [7:0] count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            delim_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            delim_reg <= delim_next;
            count_reg <= count_next;
        end
    end

    assign c         = char_in[6:0];
    assign d         = delim[6:0];
    assign ctl       = (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    assign active    = (phase_reg == PH_SKIP) || (phase_reg == PH_COLLECT);
    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        delim_next  = delim_reg;
        count_next  = count_reg;
        push        = '0;

        if (go)
        begin
            unique case (op)
                OP_BEGIN:
                begin
                    delim_next = d;
                    count_next = '0;
                    phase_next = (d == CH_SPACE) ? PH_SKIP : PH_COLLECT;
                end
                OP_END:
                begin
                    if (active)
                    begin
                        push.valid0  = 1'b1;
                        push.r0.kind = KIND_DONE;
                        push.r0.len  = count_reg;
                        push.r0.last = 1'b1;
                        phase_next   = PH_DONE;
                    end
                end
                OP_CHAR:
                begin
                    if (phase_reg == PH_SKIP && (c == CH_SPACE || ctl))
                    begin
                        // leading blank, dropped
                    end
                    else if (phase_reg == PH_COLLECT &&
                             (c == delim_reg || (delim_reg == CH_SPACE && ctl)))
                    begin
                        push.valid0  = 1'b1;
                        push.r0.kind = KIND_DONE;
                        push.r0.len  = count_reg;
                        push.r0.last = 1'b1;
                        phase_next   = PH_DONE;
                    end
                    else if (active)
                    begin
                        count_next   = count_inc;
                        phase_next   = PH_COLLECT;
                        push.valid0  = 1'b1;
                        push.r0.kind = KIND_CHAR;
                        push.r0.ch   = c;
                        push.r0.pos  = count_inc;
                        if (count_inc >= MAX_LEN)
                        begin
                            // length limit: completion follows the char
                            push.valid1  = 1'b1;
                            push.r1.kind = KIND_DONE;
                            push.r1.len  = count_inc;
                            push.r1.last = 1'b1;
                            phase_next   = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/dwt_res_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dwt_res_fifo
    import dwt_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  wire     out_ready,
    output result_t out_res
);

    result_t           mem [RES_DEPTH];
    logic [RES_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [RES_CW-1:0] count_reg;
    logic              pop;
    logic [RES_AW-1:0] wr_ptr_1;
    logic [RES_CW-1:0] n_push;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem[rd_ptr_reg];
    assign room      = (count_reg <= RES_CW'(RES_DEPTH - 2));
    assign wr_ptr_1  = wr_ptr_reg + RES_AW'(1);
    assign n_push    = RES_CW'(push.valid0) + RES_CW'(push.valid1);

    always_ff @(posedge clk)
    begin
        if (push.valid0)
            mem[wr_ptr_reg] <= push.r0;
        if (push.valid1)
            mem[wr_ptr_1] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RES_AW'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + RES_AW'(1);
            count_reg <= count_reg + n_push - RES_CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dwt_pkg::*;

    // opcode 3 has no meaning in the block; sent only as noise
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // receiver hold-off length for the back-pressure test
    localparam int HOLD_CYCLES = 60;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the tokenizer state and queues expected results
    // ------------------------------------------------------------------
    class tokenizer_scoreboard;
        phase_t     word_phase;
        logic [6:0] delim;
        logic [7:0] count;
        result_t    expected_results[$];
        int         errors;

        function new();
            word_phase = PH_IDLE;
            delim      = '0;
            count      = '0;
            errors     = 0;
        endfunction

        // word complete: one result carrying the length and tlast
        function void close_word();
            expected_results.push_back('{kind: KIND_DONE, ch: 7'd0, pos: 8'd0,
                                         len: count, last: 1'b1});
            word_phase = PH_DONE;
        endfunction

        // Applies one accepted input transfer. Returns 1 when the item is
        // acted on or skipped as a leading blank, 0 when the block simply drops it.
        function bit note_input(logic [1:0] op, logic [7:0] dl, logic [7:0] ch_in);
            logic [6:0] c;
            c = ch_in[6:0];
            if (op == OP_BEGIN) begin
                // any phase: drop the word in progress, restart
                delim      = dl[6:0];
                count      = '0;
                word_phase = (delim == CH_SPACE) ? PH_SKIP : PH_COLLECT;
                return 1'b1;
            end
            if (word_phase != PH_SKIP && word_phase != PH_COLLECT)
                return 1'b0;
            if (op == OP_END) begin
                close_word();
                return 1'b1;
            end
            if (op != OP_CHAR)
                return 1'b0;
            if (word_phase == PH_SKIP) begin
                if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})
                    return 1'b1;
                word_phase = PH_COLLECT;
            end else if (c == delim ||
                         (delim == CH_SPACE && c inside {CH_TAB, CH_LF, CH_CR})) begin
                close_word();
                return 1'b1;
            end
            count = count + 8'd1;
            expected_results.push_back('{kind: KIND_CHAR, ch: c, pos: count,
                                         len: 8'd0, last: 1'b0});
            if (count >= DEF_MAX_WORD_LEN)
                close_word();
            return 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: kind %0d char %h pos %0d len %0d last %0d",
                             got.kind, got.ch, got.pos, got.len, got.last);
                return;
            end
            want = expected_results.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected kind %0d char %h pos %0d len %0d last %0d,",
                              " got kind %0d char %h pos %0d len %0d last %0d"},
                             want.kind, want.ch, want.pos, want.len, want.last,
                             got.kind, got.ch, got.pos, got.len, got.last);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n          = 1'b0;

    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;   // [7:0] delimiter, [15:8] char_in
    logic [1:0]  s_axis_tuser   = '0;   // [1:0] opcode

    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [23:0] m_axis_tdata;          // [6:0] char, [14:7] position,
                                        // [22:15] length, [23] zero
    logic        m_axis_tuser;          // [0] kind
    logic        m_axis_tlast;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    delimited_word_tokenizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    tokenizer_scoreboard sb = new();

    // traffic shaping, percent of cycles
    int idle_pct    = 0;     // sender idles
    int stall_pct   = 0;     // receiver stalls
    int hold_req    = 0;     // bumped to request one long receiver hold-off
    int acted_items = 0;     // transfers the block acted on

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here so the
    // sender keeps pushing and the result queue backs up into s_axis_tready
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen     = hold_req;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output monitor: every accepted result goes to the scoreboard.
    // Sampled at the edge, so registered DUT outputs are pre-edge values.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result('{kind: m_axis_tuser, ch: m_axis_tdata[6:0],
                                  pos: m_axis_tdata[14:7], len: m_axis_tdata[22:15],
                                  last: m_axis_tlast});
        end
    end

    // ------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------
    // One input transfer, with random idle cycles in front of it. Each
    // step gets at most one assignment to tvalid.
    task automatic send_item(logic [1:0] op, logic [7:0] dl, logic [7:0] ch);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {ch, dl};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.note_input(op, dl, ch))
            acted_items++;
    endtask

    function automatic logic [7:0] rand_blank(bit with_space);
        logic [6:0] pick;
        case ($urandom_range(with_space ? 3 : 2))
            0:       pick = CH_TAB;
            1:       pick = CH_LF;
            2:       pick = CH_CR;
            default: pick = CH_SPACE;
        endcase
        return {1'($urandom_range(1)), pick};
    endfunction

    // One well-formed word with random content: begin, optional leading
    // blanks, body, some terminator (or none, left for the next begin).
    task automatic send_word(bit force_long);
        logic [7:0] dl;
        logic [7:0] ch;
        logic [6:0] d7;
        int         len;
        int         pick;
        pick = $urandom_range(9);
        if (pick < 4)
            dl = {1'($urandom_range(1)), CH_SPACE};
        else if (pick < 7)
            dl = 8'($urandom_range(255));
        else
            dl = {1'($urandom_range(1)), 7'($urandom_range(8'h21, 8'h7e))};
        d7 = dl[6:0];
        send_item(OP_BEGIN, dl, 8'($urandom_range(255)));
        if (d7 == CH_SPACE)
            repeat ($urandom_range(3))
                send_item(OP_CHAR, 8'($urandom_range(255)), rand_blank(1'b1));

        // mostly short words; a rare or forced one is long, near or past the length limit
        if (force_long || $urandom_range(39) == 0)
            len = $urandom_range(250, 258);
        else
            len = $urandom_range(12);
        repeat (len)
        begin
            do
                ch = 8'($urandom_range(255));
            while (ch[6:0] == d7 ||
                   (d7 == CH_SPACE && ch[6:0] inside {CH_TAB, CH_LF, CH_CR}));
            send_item(OP_CHAR, 8'($urandom_range(255)), ch);
        end

        pick = $urandom_range(9);
        if (pick < 4)
            send_item(OP_CHAR, 8'($urandom_range(255)), {1'($urandom_range(1)), d7});
        else if (pick == 4 && d7 == CH_SPACE)
            send_item(OP_CHAR, 8'($urandom_range(255)), rand_blank(1'b0));
        else if (pick < 8)
            send_item(OP_END, 8'($urandom_range(255)), 8'($urandom_range(255)));

        // trailing junk, usually dropped by the block
        if ($urandom_range(3) == 0)
            send_item(2'($urandom_range(1, 3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
    endtask

    // Mostly clean words, some raw noise with broken sequences.
    task automatic random_traffic(int count, int s_pct, int r_pct);
        int goal;
        idle_pct  = s_pct;
        stall_pct = r_pct;
        goal      = acted_items + count;
        while (acted_items < goal)
        begin
            if ($urandom_range(99) < 85)
                send_word(1'b0);
            else
                send_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dropped items, blank skipping, masking, early ends
        send_item(OP_CHAR,   8'h00, 8'h41);     // idle: dropped
        send_item(OP_END,    8'h00, 8'h00);     // idle: dropped
        send_item(OP_BEGIN,  8'h20, 8'hff);     // space delimiter
        send_item(OP_CHAR,   8'h00, 8'h20);     // leading blanks skipped
        send_item(OP_CHAR,   8'h00, 8'h89);
        send_item(OP_CHAR,   8'h00, 8'h0a);
        send_item(OP_CHAR,   8'h00, 8'h8d);
        send_item(OP_CHAR,   8'h00, 8'hff);     // 0xFF is just 0x7F
        send_item(OP_CHAR,   8'h00, 8'h00);
        send_item(OP_CHAR,   8'h00, 8'h80);
        send_item(OP_CHAR,   8'h00, 8'h09);     // tab ends a space-delimited word
        send_item(OP_CHAR,   8'h00, 8'h78);     // done: dropped
        send_item(OP_END,    8'h00, 8'h00);     // done: dropped
        send_item(OP_BEGIN,  8'hac, 8'h00);     // ',' with bit 7 set
        send_item(OP_CHAR,   8'h00, 8'h2c);     // delimiter first: empty word
        send_item(OP_BEGIN,  8'h2c, 8'h00);
        send_item(OP_CHAR,   8'h00, 8'h61);
        send_item(OP_CHAR,   8'h00, 8'h20);     // space is data here
        send_item(OP_CHAR,   8'h00, 8'h09);     // so is tab
        send_item(OP_UNUSED, 8'hff, 8'hff);     // unused opcode: dropped
        send_item(OP_BEGIN,  8'ha0, 8'h00);     // restart mid-word, space again
        send_item(OP_END,    8'h00, 8'h00);     // end while skipping: length 0
        send_item(OP_BEGIN,  8'hff, 8'h00);     // delimiter 0x7F
        send_item(OP_CHAR,   8'h00, 8'h7e);
        send_item(OP_END,    8'h00, 8'h00);

        // full-rate input with a long receiver hold-off: queue must fill
        // and push back; then a long word that may hit the length limit
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        send_word(1'b1);

        random_traffic(300,  0,  0);
        random_traffic(300, 77,  0);
        random_traffic(300,  0, 77);
        random_traffic(300, 15, 15);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // leave room for anything stray
        repeat (20) @(posedge clk);

        if (sb.pending() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
